>>> rtl/dslr_pkg.sv
`timescale 1ns / 1ps

package dslr_pkg;

  // Coordinate width; a line spans at most 2**COORD_BITS pixels.
  localparam int COORD_BITS = 6;
  localparam int COLOUR_BITS = 24;

  // Stream payload widths, rounded up to whole bytes.
  localparam int IN_FIELDS_W = 4 * COORD_BITS + COLOUR_BITS;
  localparam int IN_TDATA_W = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 * COORD_BITS + COLOUR_BITS;
  localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Remainder of the minor-axis rounding: holds up to 4 * major delta, signed.
  localparam int REM_W = COORD_BITS + 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  // One classified line, as handed from the front end to the stepper.
  typedef struct packed {
    logic                   x_major;    // x is the stepping axis
    logic [COORD_BITS-1:0]  major_start;
    logic [COORD_BITS-1:0]  minor_start;
    logic [COORD_BITS-1:0]  major_delta; // always >= 0 after the swap
    logic [COORD_BITS-1:0]  minor_mag;   // |minor delta|
    logic                   minor_neg;   // minor coordinate walks downward
    logic [COLOUR_BITS-1:0] colour;
  } cmd_t;

endpackage

>>> rtl/dslr_front.sv
`timescale 1ns / 1ps

module dslr_front (
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [dslr_pkg::IN_TDATA_W-1:0] s_tdata,
  input  logic                         q_full,
  output logic                         q_push,
  output dslr_pkg::cmd_t               q_cmd
);
  import dslr_pkg::*;

  logic [COORD_BITS-1:0] xs, ys, xe, ye;
  logic [COLOUR_BITS-1:0] col;
  logic signed [COORD_BITS:0] dx, dy, nd;
  logic [COORD_BITS:0] adx, ady;
  logic x_major;
  logic [COORD_BITS-1:0] ms, me, ns, ne, ms_sw, ns_sw, me_sw, ne_sw;
  logic swap;

  always_comb begin
    xs  = s_tdata[COORD_BITS-1:0];
    ys  = s_tdata[2*COORD_BITS-1:COORD_BITS];
    xe  = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    ye  = s_tdata[4*COORD_BITS-1:3*COORD_BITS];
    col = s_tdata[4*COORD_BITS+COLOUR_BITS-1:4*COORD_BITS];

    dx  = $signed({1'b0, xe}) - $signed({1'b0, xs});
    dy  = $signed({1'b0, ye}) - $signed({1'b0, ys});
    adx = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
    ady = dy[COORD_BITS] ? (~dy + 1'b1) : dy;
    x_major = adx > ady;

    // Pick the stepping axis; ties step along y.
    ms = x_major ? xs : ys;
    me = x_major ? xe : ye;
    ns = x_major ? ys : xs;
    ne = x_major ? ye : xe;

    // Start from the endpoint with the smaller major coordinate.
    swap  = ms > me;
    ms_sw = swap ? me : ms;
    me_sw = swap ? ms : me;
    ns_sw = swap ? ne : ns;
    ne_sw = swap ? ns : ne;
    nd    = $signed({1'b0, ne_sw}) - $signed({1'b0, ns_sw});

    q_cmd.x_major     = x_major;
    q_cmd.major_start = ms_sw;
    q_cmd.minor_start = ns_sw;
    q_cmd.major_delta = me_sw - ms_sw;
    q_cmd.minor_neg   = nd[COORD_BITS];
    q_cmd.minor_mag   = nd[COORD_BITS] ? COORD_BITS'(~nd + 1'b1) : nd[COORD_BITS-1:0];
    q_cmd.colour      = col;
  end

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

endmodule

>>> rtl/dslr_queue.sv
`timescale 1ns / 1ps

module dslr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dslr_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output dslr_pkg::cmd_t head
);
  import dslr_pkg::*;

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/dslr_back.sv
`timescale 1ns / 1ps

module dslr_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_empty,
  input  dslr_pkg::cmd_t                   q_head,
  output logic                             q_pop,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [dslr_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                             m_tlast
);
  import dslr_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                     state;
  logic                     x_major, minor_neg;
  logic [COORD_BITS-1:0]    major, minor, remaining;
  logic [COORD_BITS:0]      step2, den;
  logic signed [REM_W-1:0]  rem, rem_next, rem_sum;
  logic [COORD_BITS-1:0]    minor_next;
  logic [COLOUR_BITS-1:0]   colour;
  logic                     emit, last;
  logic [COORD_BITS-1:0]    out_x, out_y;
  logic [COLOUR_BITS-1:0]   out_colour;

  assign q_pop = (state == ST_IDLE) && !q_empty;
  assign emit  = (state == ST_RUN) && (!m_tvalid || m_tready);
  assign last  = remaining == '0;

  // Advance the rounded minor coordinate by one major step; the remainder
  // stays in [0, 2*major_delta), so one correction per step suffices.
  always_comb begin
    minor_next = minor;
    if (minor_neg) begin
      rem_sum  = rem - $signed(REM_W'(step2));
      rem_next = rem_sum;
      if (rem_sum < 0) begin
        rem_next   = rem_sum + $signed(REM_W'(den));
        minor_next = minor - 1'b1;
      end
    end else begin
      rem_sum  = rem + $signed(REM_W'(step2));
      rem_next = rem_sum;
      if (rem_sum >= $signed(REM_W'(den))) begin
        rem_next   = rem_sum - $signed(REM_W'(den));
        minor_next = minor + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (emit && last) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      x_major   <= q_head.x_major;
      minor_neg <= q_head.minor_neg;
      major     <= q_head.major_start;
      minor     <= q_head.minor_start;
      remaining <= q_head.major_delta;
      step2     <= {q_head.minor_mag, 1'b0};
      den       <= {q_head.major_delta, 1'b0};
      rem       <= $signed(REM_W'(q_head.major_delta));
      colour    <= q_head.colour;
    end else if (emit) begin
      major     <= major + 1'b1;
      minor     <= minor_next;
      rem       <= rem_next;
      remaining <= remaining - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_x      <= x_major ? major : minor;
      out_y      <= x_major ? minor : major;
      out_colour <= colour;
      m_tlast    <= last;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, out_colour, out_y, out_x};

endmodule

>>> rtl/direct_slope_line_rasterizer_core.sv
`timescale 1ns / 1ps
// A request is written into the queue, loaded by the stepper, and its pixels leave through a register.
// The stepper emits one pixel per cycle while m_tready is high; a line of n major steps
// gives n + 1 pixels; each line is loaded from the queue before its first pixel.
// A two-entry queue takes new requests while the stepper draws the current line.
// Reset (rst, synchronous): empties the queue, idles the stepper, drops m_tvalid.

module direct_slope_line_rasterizer_core (
  input  logic                             clk,
  input  logic                             rst,
  // Request stream. s_tdata, low bit up: start_x, start_y, end_x, end_y, colour.
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [dslr_pkg::IN_TDATA_W-1:0]  s_tdata,
  // Pixel stream. m_tdata, low bit up: pixel_x, pixel_y, pixel_colour, zero pad.
  // m_tlast carries last_pixel.
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [dslr_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                             m_tlast
);
  import dslr_pkg::*;

  cmd_t front_cmd, head_cmd;
  logic q_push, q_full, q_pop, q_empty;

  // Front end: pick the stepping axis and start endpoint, then enqueue.
  dslr_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (front_cmd)
  );

  // Decouple request intake from pixel generation.
  dslr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (head_cmd)
  );

  // Back end: walk the major axis, track the rounded minor coordinate
  // with an exact remainder, and register each pixel for the output.
  dslr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (head_cmd),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import dslr_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int COORD_MAX = (1 << CB) - 1;
  localparam int RAND_LINES = 300;
  localparam int LONG_HOLD = 300;   // receiver hold-off, long enough to back up the queue
  localparam int DRAIN_CYCLES = 20; // extra wait after the last owed pixel, to catch stray output
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [CB-1:0]          start_x;
    logic [CB-1:0]          start_y;
    logic [CB-1:0]          end_x;
    logic [CB-1:0]          end_y;
    logic [COLOUR_BITS-1:0] colour;
  } line_t;

  typedef struct packed {
    logic [CB-1:0]          x;
    logic [CB-1:0]          y;
    logic [COLOUR_BITS-1:0] colour;
    logic                   last;
  } pixel_t;

  // Directed request; when typed is set the single pixel (px, py) is the whole answer.
  typedef struct packed {
    logic [CB-1:0]          sx;
    logic [CB-1:0]          sy;
    logic [CB-1:0]          ex;
    logic [CB-1:0]          ey;
    logic [COLOUR_BITS-1:0] colour;
    logic                   typed;
    logic [CB-1:0]          px;
    logic [CB-1:0]          py;
  } dir_row_t;

  localparam int NUM_DIR = 22;

  dir_row_t dir_rows [0:NUM_DIR-1] = '{
    // zero-length lines: one pixel at the start point
    '{0, 0, 0, 0, 24'h000000, 1, 0, 0},
    '{63, 63, 63, 63, 24'hFFFFFF, 1, 63, 63},
    '{17, 42, 17, 42, 24'hA5A55A, 1, 17, 42},
    // full-span horizontal and vertical, both directions
    '{0, 0, 63, 0, 24'hFFFFFF, 0, 0, 0},
    '{63, 63, 0, 63, 24'h000000, 0, 0, 0},
    '{0, 0, 0, 63, 24'h123456, 0, 0, 0},
    '{5, 63, 5, 0, 24'h654321, 0, 0, 0},
    // diagonal ties step in y
    '{0, 0, 63, 63, 24'h800001, 0, 0, 0},
    '{63, 0, 0, 63, 24'h7FFFFE, 0, 0, 0},
    '{63, 63, 0, 0, 24'h0F0F0F, 0, 0, 0},
    // exact halves round toward +infinity, both minor directions
    '{0, 0, 2, 1, 24'h111111, 0, 0, 0},
    '{0, 1, 2, 0, 24'h222222, 0, 0, 0},
    '{2, 0, 0, 1, 24'h333333, 0, 0, 0},
    '{0, 0, 1, 2, 24'h444444, 0, 0, 0},
    '{1, 0, 0, 2, 24'h555555, 0, 0, 0},
    // general slopes, forward and swapped
    '{10, 20, 50, 30, 24'hC0FFEE, 0, 0, 0},
    '{50, 30, 10, 20, 24'hBADA55, 0, 0, 0},
    '{0, 63, 63, 62, 24'hF00F00, 0, 0, 0},
    '{31, 0, 32, 63, 24'h0FF0FF, 0, 0, 0},
    '{0, 0, 1, 0, 24'hAAAAAA, 0, 0, 0},
    '{40, 40, 40, 41, 24'h555AAA, 0, 0, 0},
    '{63, 0, 0, 1, 24'hDEAD00, 0, 0, 0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic m_tlast;

  pixel_t pixel_q [$];   // pixels still owed by the block, oldest first
  int errors = 0;
  int lines_sent = 0;
  int pixels_seen = 0;
  int longest_line = 0;
  bit sink_hold = 0;     // sender asks the receiver for one long hold-off
  bit steady = 0;        // no idling on either side

  direct_slope_line_rasterizer_core dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #100_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // n / d rounded to nearest, halves up; d > 0
  function automatic int round_half_up(int n, int d);
    int num, den;
    num = 2 * n + d;
    den = 2 * d;
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  // Queue every pixel of one line in stepping order.
  function automatic void plot_line(line_t ln);
    int xs, ys, xe, ye, dx, dy, adx, ady;
    int ms, me, ns, ne, md, nd, tmp, minor, major, t;
    bit x_major;
    pixel_t px;
    xs = ln.start_x;
    ys = ln.start_y;
    xe = ln.end_x;
    ye = ln.end_y;
    dx = xe - xs;
    dy = ye - ys;
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    x_major = adx > ady;
    if (x_major) begin
      ms = xs; me = xe; ns = ys; ne = ye;
    end else begin
      ms = ys; me = ye; ns = xs; ne = xe;
    end
    if (ms > me) begin
      tmp = ms; ms = me; me = tmp;
      tmp = ns; ns = ne; ne = tmp;
    end
    md = me - ms;
    nd = ne - ns;
    if (md + 1 > longest_line) longest_line = md + 1;
    for (t = 0; t <= md; t++) begin
      minor = (md == 0) ? ns : ns + round_half_up(nd * t, md);
      major = ms + t;
      px.x = CB'(x_major ? major : minor);
      px.y = CB'(x_major ? minor : major);
      px.colour = ln.colour;
      px.last = (t == md);
      pixel_q.push_back(px);
    end
  endfunction

  function automatic int near_coord(int c);
    int v;
    v = c + int'($urandom_range(0, 14)) - 7;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return v;
  endfunction

  // Mostly back to back, sometimes a short gap, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 65) return 0;
    if (r < 95) return int'($urandom_range(1, 3));
    return int'($urandom_range(20, 60));
  endfunction

  // Offer one request and return at the edge that accepts it.
  task automatic send_line(input line_t ln);
    s_tdata <= {ln.colour, ln.end_y, ln.end_x, ln.start_y, ln.start_x};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    lines_sent++;
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  initial begin : feeder
    line_t ln;
    pixel_t one;
    int kind, d, tmp;
    @(posedge clk);
    while (rst) @(posedge clk);

    for (int i = 0; i < NUM_DIR; i++) begin
      ln.start_x = dir_rows[i].sx;
      ln.start_y = dir_rows[i].sy;
      ln.end_x = dir_rows[i].ex;
      ln.end_y = dir_rows[i].ey;
      ln.colour = dir_rows[i].colour;
      send_line(ln);
      if (dir_rows[i].typed) begin
        one.x = dir_rows[i].px;
        one.y = dir_rows[i].py;
        one.colour = dir_rows[i].colour;
        one.last = 1'b1;
        pixel_q.push_back(one);
      end else begin
        plot_line(ln);
      end
      idle_gap(pick_gap());
    end

    for (int i = 0; i < RAND_LINES; i++) begin
      if (i == 20) sink_hold = 1;
      if (i == 120) steady = 1;
      if (i == 160) steady = 0;
      // drain completely once mid-run
      if (i == 200) begin
        s_tvalid <= 1'b0;
        wait (pixel_q.size() == 0);
        @(posedge clk);
      end

      kind = int'($urandom_range(0, 99));
      ln.colour = COLOUR_BITS'($urandom());
      ln.start_x = CB'($urandom_range(0, COORD_MAX));
      ln.start_y = CB'($urandom_range(0, COORD_MAX));
      if (kind < 45) begin
        ln.end_x = CB'($urandom_range(0, COORD_MAX));
        ln.end_y = CB'($urandom_range(0, COORD_MAX));
      end else if (kind < 80) begin
        ln.end_x = CB'(near_coord(ln.start_x));
        ln.end_y = CB'(near_coord(ln.start_y));
      end else if (kind < 90) begin
        ln.end_x = ln.start_x;
        ln.end_y = ln.start_y;
      end else if (kind < 95) begin
        ln.end_x = CB'($urandom_range(0, COORD_MAX));
        ln.end_y = CB'($urandom_range(0, COORD_MAX));
        if ($urandom_range(0, 1)) ln.end_x = ln.start_x;
        else ln.end_y = ln.start_y;
      end else begin
        d = int'($urandom_range(0, COORD_MAX));
        ln.start_x = CB'($urandom_range(0, COORD_MAX - d));
        ln.start_y = CB'($urandom_range(0, COORD_MAX - d));
        ln.end_x = CB'(ln.start_x + d);
        ln.end_y = CB'(ln.start_y + d);
        if ($urandom_range(0, 1)) begin
          tmp = ln.start_y;
          ln.start_y = ln.end_y;
          ln.end_y = CB'(tmp);
        end
      end

      send_line(ln);
      plot_line(ln);
      if (steady || (i >= 20 && i < 40)) idle_gap(0);
      else idle_gap(pick_gap());
    end

    s_tvalid <= 1'b0;
    wait (pixel_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d line requests (%0d directed), %0d pixels checked, longest line %0d pixels",
             lines_sent, NUM_DIR, pixels_seen, longest_line);
    $display("covered zero-length, axis-aligned, diagonal and half-rounding lines, both sides stalling");
    if (errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

  initial begin : sink
    int r;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (sink_hold) begin
        sink_hold = 0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (steady) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        r = int'($urandom_range(0, 99));
        if (r < 60) begin
          m_tready <= 1'b1;
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end else if (r < 95) begin
          m_tready <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk);
        end else begin
          m_tready <= 1'b0;
          repeat ($urandom_range(20, 80)) @(posedge clk);
        end
      end
    end
  end

  // Compare every accepted pixel with the oldest one owed.
  always @(posedge clk) begin
    pixel_t got, want;
    logic [OUT_TDATA_W-OUT_FIELDS_W-1:0] pad;
    if (!rst && m_tvalid && m_tready) begin
      got.x = m_tdata[CB-1:0];
      got.y = m_tdata[2*CB-1:CB];
      got.colour = m_tdata[2*CB+COLOUR_BITS-1:2*CB];
      got.last = m_tlast;
      pad = m_tdata[OUT_TDATA_W-1:OUT_FIELDS_W];
      pixels_seen++;
      if (pixel_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected pixel: x=%0d y=%0d colour=%06h last=%0b",
                   $time, got.x, got.y, got.colour, got.last);
      end else begin
        want = pixel_q.pop_front();
        if (got !== want || pad !== '0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: pixel mismatch: expected x=%0d y=%0d colour=%06h last=%0b pad=0, got x=%0d y=%0d colour=%06h last=%0b pad=%0h",
                     $time, want.x, want.y, want.colour, want.last,
                     got.x, got.y, got.colour, got.last, pad);
        end
      end
    end
  end

endmodule
